/* hdl/assert_macros.svh */
// Assertion macros used by the controller core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define TPC_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tpc assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define TPC_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("tpc assertion failed");

`endif

/* hdl/tpc_pkg.sv */
// Package for the tilt position controller: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

	// width of the position count
	localparam int COUNT_WIDTH = 32;

	// divider shape for the speed ramp: (8 bit span) * (16 bit distance) / 16 bit zone
	localparam int DIV_N = 24;
	localparam int DIV_D = 16;
	localparam int DIV_CNT_W = $clog2(DIV_N);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_CTRL = 2'd1;
	localparam logic [1:0] CMD_ZERO = 2'd2;

	// drive status codes
	localparam logic [1:0] STAT_DRIVE = 2'd0;
	localparam logic [1:0] STAT_AT_TARGET = 2'd1;
	localparam logic [1:0] STAT_GRAVITY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_ZONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_EARLY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd4;

	localparam logic [7:0] DUTY_FULL = 8'd255;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [31:0] target;
		logic [7:0] speed;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pwm_duty;
		logic bridge_in2;
		logic [1:0] drive_status;
		logic signed [31:0] position;
	} out_word_t;

	// divider request and response
	typedef struct packed {
		logic start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_N-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MAG,
		ST_DECIDE,
		ST_DIV,
		ST_EMIT
	} tpc_state_t;

endpackage

`default_nettype wire

/* hdl/tpc_div.sv */
// Restoring serial divider, one quotient bit per cycle, for the speed ramp.
`timescale 1ns / 1ps
`default_nettype none

module tpc_div (
	input  wire              clk,
	input  wire              arst_n,
	input  wire tpc_pkg::div_req_t req,
	output tpc_pkg::div_rsp_t rsp
);
	import tpc_pkg::*;

	logic [DIV_D:0] rem_q;
	logic [DIV_N-1:0] quo_q;
	logic [DIV_D-1:0] divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DIV_D:0] shifted;
	logic [DIV_D+1:0] trial;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		shifted = {rem_q[DIV_D-1:0], quo_q[DIV_N-1]};
		trial = {1'b0, shifted} - {2'b00, divisor_q};
	end

	// control: count the steps and flag the finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[DIV_D+1]) begin
				rem_q <= trial[DIV_D:0];
			end else begin
				rem_q <= shifted;
			end
			quo_q <= {quo_q[DIV_N-2:0], ~trial[DIV_D+1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hdl/tilt_position_controller_core.sv */
// Top level of the tilt position controller: sequencer, state and result register.
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid/in_ready   | in_word   (cmd, target, speed)
//  out     | out       | out_valid/out_ready | out_word  (duty, in2, status, position)
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// Edge and zero words are handled without leaving the idle state; cmd 3 is taken and dropped.
// A control word steps through DIFF, MAG, DECIDE and EMIT when it brakes or runs at its
// commanded speed, and through DIV before EMIT on the ramp, where the serial divider runs.
// Reset is asynchronous; there is no clearing pass.
// in_ready is low while a control word is in work; a result held by out_ready
// stalls only the next control word from leaving its final step.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tilt_position_controller_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire tpc_pkg::in_word_t             in_word,
	output logic                               out_valid,
	input  wire                                out_ready,
	output tpc_pkg::out_word_t                 out_word,
	input  wire                                cfg_we,
	input  wire  [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [tpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tpc_pkg::*;

	// configuration
	logic [15:0] dead_band_q;
	logic [15:0] slow_zone_q;
	logic [7:0] min_speed_q;
	logic [15:0] brake_early_q;
	logic gravity_q;

	// controller state
	logic [COUNT_WIDTH-1:0] pos_q;
	logic fwd_q;

	// control word in work
	tpc_state_t state_q, state_d;
	logic [COUNT_WIDTH-1:0] target_q;
	logic [7:0] speed_q;
	logic [COUNT_WIDTH-1:0] diff_q;
	logic [COUNT_WIDTH-1:0] mag_q;
	logic decrease_q;
	out_word_t res_q;

	// output register
	logic out_valid_q;
	out_word_t out_word_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_take;
	logic near_target;
	logic near_gravity;
	logic on_ramp;
	logic emit_load;

	tpc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// build a driving result from the effective duty
	function automatic out_word_t drive_word(input logic [7:0] eff, input logic decrease,
			input logic [COUNT_WIDTH-1:0] pos);
		out_word_t w;
		w.drive_status = STAT_DRIVE;
		w.position = 32'($signed(pos));
		if (decrease) begin
			w.pwm_duty = eff;
			w.bridge_in2 = 1'b0;
		end else begin
			w.pwm_duty = DUTY_FULL - eff;
			w.bridge_in2 = 1'b1;
		end
		return w;
	endfunction

	// build a braking result
	function automatic out_word_t brake_word(input logic [1:0] status,
			input logic [COUNT_WIDTH-1:0] pos);
		out_word_t w;
		w.pwm_duty = DUTY_FULL;
		w.bridge_in2 = 1'b1;
		w.drive_status = status;
		w.position = 32'($signed(pos));
		return w;
	endfunction

	// decision compares on the registered magnitude
	always_comb begin
		near_target = mag_q < COUNT_WIDTH'(dead_band_q);
		near_gravity = (decrease_q == gravity_q) && (mag_q < COUNT_WIDTH'(brake_early_q));
		on_ramp = (speed_q > min_speed_q) && (mag_q < COUNT_WIDTH'(slow_zone_q));
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		in_take = 1'b0;
		emit_load = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = 24'(speed_q - min_speed_q) * 24'(mag_q[15:0]);
		div_req.divisor = slow_zone_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				in_take = in_valid;
				if (in_valid && in_word.cmd == CMD_CTRL) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				state_d = ST_MAG;
			end
			ST_MAG: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!near_target && !near_gravity && on_ramp) begin
					div_req.start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= 16'd50;
			slow_zone_q <= 16'd800;
			min_speed_q <= 8'd30;
			brake_early_q <= 16'd250;
			gravity_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEAD_BAND:   dead_band_q <= cfg_data;
				REG_SLOW_ZONE:   slow_zone_q <= cfg_data;
				REG_MIN_SPEED:   min_speed_q <= cfg_data[7:0];
				REG_BRAKE_EARLY: brake_early_q <= cfg_data;
				REG_GRAVITY:     gravity_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// position count and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fwd_q <= 1'b1;
		end else begin
			if (in_take && in_word.cmd == CMD_EDGE) begin
				if (fwd_q) begin
					pos_q <= pos_q + 1'b1;
				end else begin
					pos_q <= pos_q - 1'b1;
				end
			end else if (in_take && in_word.cmd == CMD_ZERO) begin
				pos_q <= '0;
			end
			if ((state_q == ST_DECIDE && !near_target && !near_gravity && !on_ramp) ||
					(state_q == ST_DIV && div_rsp.done)) begin
				fwd_q <= !decrease_q;
			end
		end
	end

	// control word datapath: latch, subtract, magnitude, decide
	always_ff @(posedge clk) begin
		if (in_take) begin
			target_q <= COUNT_WIDTH'(in_word.target);
			speed_q <= in_word.speed;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= pos_q - target_q;
		end
		if (state_q == ST_MAG) begin
			mag_q <= diff_q[COUNT_WIDTH-1] ? (~diff_q + 1'b1) : diff_q;
			decrease_q <= !diff_q[COUNT_WIDTH-1] && (|diff_q);
		end
		if (state_q == ST_DECIDE) begin
			if (near_target) begin
				res_q <= brake_word(STAT_AT_TARGET, pos_q);
			end else if (near_gravity) begin
				res_q <= brake_word(STAT_GRAVITY, pos_q);
			end else begin
				res_q <= drive_word(speed_q, decrease_q, pos_q);
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			res_q <= drive_word(min_speed_q + div_rsp.quotient[7:0], decrease_q, pos_q);
		end
	end

	// output register: load a finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	`TPC_ASSERT(a_div_done_in_div, !div_rsp.done || state_q == ST_DIV)
	`TPC_ASSERT_NEXT(a_edge_steps, in_valid && in_ready && in_word.cmd == CMD_EDGE,
		pos_q == ($past(fwd_q) ? $past(pos_q) + 1'b1 : $past(pos_q) - 1'b1))
	`TPC_ASSERT(a_brake_levels, !out_valid_q || out_word_q.drive_status == STAT_DRIVE ||
		(out_word_q.pwm_duty == DUTY_FULL && out_word_q.bridge_in2))

endmodule

`default_nettype wire
